// ===== design/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescape unit.
// Used by the front decoder, the bundle queue, the back serializer and the top level.
// No dependencies.
package jsu_pkg;

	// Depth of the bundle queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Characters with special meaning inside a string body.
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;

	// Control bytes that the one-letter escapes stand for.
	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_CR = 8'h0D;
	localparam logic [7:0] CTL_HT = 8'h09;

	// UTF-8 range limits and lead/continuation marks.
	localparam logic [15:0] UTF8_MAX1 = 16'h007F;
	localparam logic [15:0] UTF8_MAX2 = 16'h07FF;
	localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0] UTF8_CONT = 8'h80;
	localparam logic [7:0] UTF8_CONT_MASK = 8'h3F;

	// Decoder state.
	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_TEXT = 3'd1,
		MODE_ESC = 3'd2,
		MODE_HEX = 3'd3,
		MODE_DONE = 3'd4,
		MODE_ERR = 3'd5
	} mode_t;

	// Kind of one result.
	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR = 2'd2
	} kind_t;

	// Status result that follows the decoded bytes of one input, if any.
	typedef enum logic [1:0] {
		TAIL_NONE = 2'd0,
		TAIL_DONE = 2'd1,
		TAIL_ERR = 2'd2
	} tail_t;

	// One input transaction.
	typedef struct packed {
		logic [7:0] in_byte;
		logic string_start;
		logic input_end;
	} in_item_t;

	// One result transaction.
	typedef struct packed {
		logic [7:0] out_byte;
		kind_t kind;
		logic run_last;
	} out_item_t;

	// All results caused by one input: up to three bytes, then an optional status.
	typedef struct packed {
		logic [1:0] nbytes;
		logic [2:0][7:0] bytes;
		tail_t tail;
	} bundle_t;

	// Head of the bundle queue as seen by the back serializer.
	typedef struct packed {
		logic valid;
		bundle_t bundle;
	} q_head_t;

endpackage

// ===== design/jsu_front.sv =====
// Front decoder: accepts raw string bytes and turns each into a result bundle.
// Depends on jsu_pkg.
module jsu_front
	import jsu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic take,
	input in_item_t item,
	output logic bundle_we,
	output bundle_t bundle
);

	mode_t mode_q;
	logic [1:0] hex_count_q;
	logic [15:0] code_accum_q;

	mode_t mode_cur;
	logic [1:0] cnt_cur;
	logic [15:0] acc_cur;
	mode_t mode_nxt;
	logic [1:0] cnt_nxt;
	logic [15:0] acc_nxt;
	logic [7:0] c;
	logic [7:0] hex_diff;
	logic hex_ok;
	logic [15:0] acc_shift;

	assign c = item.in_byte;

	// Hex digit recognition, either case.
	always_comb begin
		hex_ok = 1'b1;
		hex_diff = 8'h00;
		if (c inside {[8'h30:8'h39]}) begin
			hex_diff = c - 8'h30;
		end else if (c inside {[8'h61:8'h66]}) begin
			hex_diff = c - 8'h57;
		end else if (c inside {[8'h41:8'h46]}) begin
			hex_diff = c - 8'h37;
		end else begin
			hex_ok = 1'b0;
		end
	end

	// A start flag restarts the decoder before this byte is decoded.
	always_comb begin
		mode_cur = item.string_start ? MODE_TEXT : mode_q;
		cnt_cur = item.string_start ? 2'd0 : hex_count_q;
		acc_cur = item.string_start ? 16'h0000 : code_accum_q;
	end

	assign acc_shift = {acc_cur[11:0], hex_diff[3:0]};

	// Decode one byte into its bundle and the next decoder state.
	always_comb begin
		mode_nxt = mode_cur;
		cnt_nxt = cnt_cur;
		acc_nxt = acc_cur;
		bundle = '0;
		bundle.tail = TAIL_NONE;
		case (mode_cur)
			MODE_TEXT: begin
				if (c == CH_QUOTE) begin
					bundle.tail = TAIL_DONE;
					mode_nxt = MODE_DONE;
				end else if (c == CH_BSLASH) begin
					mode_nxt = MODE_ESC;
				end else begin
					bundle.nbytes = 2'd1;
					bundle.bytes[0] = c;
				end
			end
			MODE_ESC: begin
				mode_nxt = MODE_TEXT;
				bundle.nbytes = 2'd1;
				case (c)
					CH_QUOTE, CH_BSLASH, CH_SLASH: bundle.bytes[0] = c;
					CH_B: bundle.bytes[0] = CTL_BS;
					CH_F: bundle.bytes[0] = CTL_FF;
					CH_N: bundle.bytes[0] = CTL_LF;
					CH_R: bundle.bytes[0] = CTL_CR;
					CH_T: bundle.bytes[0] = CTL_HT;
					CH_U: begin
						bundle.nbytes = 2'd0;
						mode_nxt = MODE_HEX;
						cnt_nxt = 2'd0;
						acc_nxt = 16'h0000;
					end
					default: begin
						bundle.nbytes = 2'd0;
						bundle.tail = TAIL_ERR;
						mode_nxt = MODE_ERR;
					end
				endcase
			end
			MODE_HEX: begin
				if (!hex_ok) begin
					bundle.tail = TAIL_ERR;
					mode_nxt = MODE_ERR;
				end else if (cnt_cur == 2'd3) begin
					// Fourth digit: encode the gathered code point as UTF-8.
					if (acc_shift <= UTF8_MAX1) begin
						bundle.nbytes = 2'd1;
						bundle.bytes[0] = acc_shift[7:0];
					end else if (acc_shift <= UTF8_MAX2) begin
						bundle.nbytes = 2'd2;
						bundle.bytes[0] = UTF8_LEAD2 | {3'b000, acc_shift[10:6]};
						bundle.bytes[1] = UTF8_CONT | ({2'b00, acc_shift[5:0]} & UTF8_CONT_MASK);
					end else begin
						bundle.nbytes = 2'd3;
						bundle.bytes[0] = UTF8_LEAD3 | {4'h0, acc_shift[15:12]};
						bundle.bytes[1] = UTF8_CONT | {2'b00, acc_shift[11:6]};
						bundle.bytes[2] = UTF8_CONT | ({2'b00, acc_shift[5:0]} & UTF8_CONT_MASK);
					end
					cnt_nxt = 2'd0;
					acc_nxt = 16'h0000;
					mode_nxt = MODE_TEXT;
				end else begin
					cnt_nxt = cnt_cur + 2'd1;
					acc_nxt = acc_shift;
				end
			end
			default: begin
				// Idle, done or error: the byte is ignored.
			end
		endcase

		// Input that ends inside an open string is an error.
		if (item.input_end && (mode_nxt == MODE_TEXT || mode_nxt == MODE_ESC ||
				mode_nxt == MODE_HEX)) begin
			bundle.tail = TAIL_ERR;
			mode_nxt = MODE_ERR;
			cnt_nxt = 2'd0;
			acc_nxt = 16'h0000;
		end
	end

	// Only inputs that cause at least one result occupy the queue.
	assign bundle_we = take && (bundle.nbytes != 2'd0 || bundle.tail != TAIL_NONE);

	// Decoder state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			hex_count_q <= 2'd0;
			code_accum_q <= 16'h0000;
		end else if (take) begin
			mode_q <= mode_nxt;
			hex_count_q <= cnt_nxt;
			code_accum_q <= acc_nxt;
		end
	end

endmodule

// ===== design/jsu_queue.sv =====
// Short queue of result bundles between the front decoder and the back serializer.
// Depends on jsu_pkg.
module jsu_queue
	import jsu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input bundle_t wr_data,
	input logic rd_en,
	output logic full,
	output q_head_t head
);

	bundle_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.bundle = mem_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && head.valid;

	// Entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= QPTR_W'((32'(wr_ptr_q) + 1) % QUEUE_DEPTH);
			end
			if (do_rd) begin
				rd_ptr_q <= QPTR_W'((32'(rd_ptr_q) + 1) % QUEUE_DEPTH);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== design/jsu_back.sv =====
// Back serializer: walks the head bundle and presents its results one at a time.
// Depends on jsu_pkg.
module jsu_back
	import jsu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input q_head_t head,
	input logic pop,
	output logic empty,
	output out_item_t result,
	output logic deq
);

	logic [1:0] idx_q;
	logic [2:0] total;
	logic is_last;
	logic taken;

	// Number of results in the head bundle and whether this one closes it.
	assign total = {1'b0, head.bundle.nbytes} + {2'b00, head.bundle.tail != TAIL_NONE};
	assign is_last = ({1'b0, idx_q} + 3'd1) == total;
	assign empty = !head.valid;
	assign taken = pop && head.valid;
	assign deq = taken && is_last;

	// Result selection: decoded bytes first, then the status.
	always_comb begin
		result.run_last = is_last;
		if ({1'b0, idx_q} < {1'b0, head.bundle.nbytes}) begin
			result.out_byte = head.bundle.bytes[idx_q];
			result.kind = KIND_BYTE;
		end else begin
			result.out_byte = 8'h00;
			result.kind = (head.bundle.tail == TAIL_DONE) ? KIND_DONE : KIND_ERR;
		end
	end

	// Position within the head bundle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (taken) begin
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// ===== design/json_string_unescape_utf8_unit.sv =====
// JSON string body decoder with UTF-8 output; top level of the unit.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.

// One input transaction is taken per clock cycle whenever the bundle queue has room; the
// front decoder finishes each byte in the cycle it is accepted. An input yields zero to
// four results (up to three UTF-8 bytes and an error), and the back serializer hands out one
// result per cycle while pop is asserted, so the results of one input leave in turn.
// A four-entry bundle queue between the two sides absorbs bursts such as the
// three-byte output of a \u escape, which always follows five silent input bytes.
// Inputs that yield no result never enter the queue. After reset the decoder is idle
// and ignores bytes until one arrives with string_start set.
module json_string_unescape_utf8_unit
	import jsu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input in_item_t item,
	output logic empty,
	input logic pop,
	output out_item_t result
);

	logic bundle_we;
	bundle_t bundle;
	q_head_t head;
	logic deq;
	logic take;

	assign take = push && !full;

	jsu_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.item(item),
		.bundle_we(bundle_we),
		.bundle(bundle)
	);

	jsu_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(bundle_we),
		.wr_data(bundle),
		.rd_en(deq),
		.full(full),
		.head(head)
	);

	jsu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.empty(empty),
		.result(result),
		.deq(deq)
	);

endmodule
